>>> rtl/adk_pkg.sv
// Shared types, constants and the arctangent table of the Ackermann drive kinematics block.
package adk_pkg;

    // Geometry limits and fixed-point constants.
    localparam int unsigned STEER_CAP   = 25000;
    localparam int unsigned DEAD_BAND   = 16;
    localparam int unsigned HALF_PI_Q14 = 25736;
    localparam int unsigned CORDIC_N    = 24;
    localparam int unsigned KINV        = 652032874;
    localparam int unsigned NORM_STEPS  = 6;
    localparam int unsigned QW          = 17;

    // Register reset values.
    localparam logic [15:0] WHEELBASE_RST = 16'd9503;
    localparam logic [15:0] TRACK_RST     = 16'd8716;
    localparam logic [15:0] RADIUS_RST    = 16'd2195;
    localparam logic [14:0] STEER_LIM_RST = 15'd8192;
    localparam logic [14:0] SPEED_LIM_RST = 15'd9830;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_WHEELBASE = 3'd0,
        REG_TRACK     = 3'd1,
        REG_RADIUS    = 3'd2,
        REG_STEER_LIM = 3'd3,
        REG_SPEED_LIM = 3'd4
    } t_reg_idx;

    // Input word: steering and speed commands.
    typedef struct packed {
        logic signed [15:0] steer_cmd;
        logic signed [15:0] speed_cmd;
    } t_in;

    // Output word: wheel angles, wheel rates and flags.
    typedef struct packed {
        logic signed [15:0] left_angle;
        logic signed [15:0] right_angle;
        logic signed [15:0] left_rate;
        logic signed [15:0] right_rate;
        logic               speed_scaled;
        logic               geometry_fault;
    } t_out;

    // Working state of one word as it moves down the chain of cells.
    typedef struct packed {
        logic               left;
        logic               straight;
        logic               vneg;
        logic [14:0]        m;
        logic signed [32:0] rx;
        logic signed [32:0] ry;
        logic signed [32:0] rz;
        logic [16:0]        c16;
        logic [16:0]        s16;
        logic [33:0]        dc;
        logic [32:0]        ts;
        logic [33:0]        nv;
        logic [34:0]        dp;
        logic [34:0]        dmag;
        logic               dmneg;
        logic               fault;
        logic signed [44:0] ox;
        logic signed [44:0] oy;
        logic signed [32:0] oz;
        logic signed [44:0] ix;
        logic signed [44:0] iy;
        logic signed [32:0] iz;
        logic [14:0]        oang;
        logic [14:0]        iang;
        logic [49:0]        p_mdp;
        logic [48:0]        p_ldc;
        logic [49:0]        p_mdm;
        logic [49:0]        p_ldm;
        logic [49:0]        p_dcr;
        logic [50:0]        p_dpr;
        logic               scaled;
        logic [63:0]        rem_o;
        logic [63:0]        rem_i;
        logic [51:0]        dd_o;
        logic [51:0]        dd_i;
        logic               ovf_o;
        logic               ovf_i;
        logic [QW-1:0]      q_o;
        logic [QW-1:0]      q_i;
    } t_item;

    // Arctangent of 2^-i in units of 2^-30 rad.
    function automatic logic [29:0] atan_q30(input int unsigned i);
        logic [29:0] r;
        case (i)
            0:       r = 30'd843314856;
            1:       r = 30'd497837829;
            2:       r = 30'd263043836;
            3:       r = 30'd133525158;
            4:       r = 30'd67021686;
            5:       r = 30'd33543515;
            6:       r = 30'd16775850;
            7:       r = 30'd8388437;
            8:       r = 30'd4194282;
            9:       r = 30'd2097149;
            10:      r = 30'd1048575;
            11:      r = 30'd524287;
            12:      r = 30'd262143;
            13:      r = 30'd131071;
            14:      r = 30'd65535;
            15:      r = 30'd32767;
            16:      r = 30'd16383;
            17:      r = 30'd8191;
            18:      r = 30'd4095;
            19:      r = 30'd2047;
            20:      r = 30'd1023;
            21:      r = 30'd511;
            22:      r = 30'd255;
            23:      r = 30'd127;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/ackermann_drive_kinematics.sv
// Ackermann front steering and rear differential: a fully pipelined chain of cells.
// Throughput: one word per cycle while the skid register is empty; the chain of
// 24 rotation, 6 normalize, 24 vectoring and 17 divide cells plus 8 setup stages
// holds one word in each stage.
// A skid register behind the output register keeps the chain moving while a result waits.
// Reset (synchronous, active low) empties the chain and loads the register defaults.
module ackermann_drive_kinematics
    import adk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_word
);

    // Configuration registers.
    logic [15:0] r_wheelbase;
    logic [15:0] r_track;
    logic [15:0] r_radius;
    logic [14:0] r_steer_lim;
    logic [14:0] r_speed_lim;
    logic [14:0] w_slim;
    logic [15:0] w_l;
    logic [15:0] w_r;

    // Chain enable and output side.
    logic  w_en;
    logic  r_out_vld;
    t_out  r_out_word;
    logic  r_skid_vld;
    t_out  r_skid_word;
    t_out  w_fmt;

    // Setup stages.
    logic  r_s0_vld, r_cs_vld, r_m1_vld, r_ad_vld, r_an_vld, r_m2_vld, r_se_vld, r_ov_vld;
    t_item r_s0, r_cs, r_m1, r_ad, r_an, r_m2, r_se, r_ov;
    t_item n_s0, n_cs, n_m1, n_ad, n_an, n_m2, n_se, n_ov;

    // Cell chains.
    logic  w_rot_vld  [CORDIC_N+1];
    t_item w_rot_item [CORDIC_N+1];
    logic  r_nm_vld   [NORM_STEPS];
    t_item r_nm_item  [NORM_STEPS];
    logic  w_vec_vld  [CORDIC_N+1];
    t_item w_vec_item [CORDIC_N+1];
    logic  w_div_vld  [QW+1];
    t_item w_div_item [QW+1];

    // Temporaries of the setup stages.
    logic signed [16:0] w_sc;
    logic signed [16:0] w_v;
    logic signed [16:0] w_slim_s;
    logic signed [16:0] w_vlim_s;
    logic signed [16:0] w_a;
    logic signed [16:0] w_m;
    logic signed [33:0] w_cr;
    logic signed [33:0] w_sr;
    logic signed [33:0] w_c;
    logic signed [33:0] w_s;
    logic signed [35:0] w_dm;
    logic signed [32:0] w_oa;
    logic signed [32:0] w_ia;
    logic [61:0]        w_no;
    logic [61:0]        w_ni;
    logic [50:0]        w_do;
    logic [50:0]        w_di;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheelbase <= WHEELBASE_RST;
            r_track     <= TRACK_RST;
            r_radius    <= RADIUS_RST;
            r_steer_lim <= STEER_LIM_RST;
            r_speed_lim <= SPEED_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WHEELBASE: r_wheelbase <= i_cfg_data;
                REG_TRACK:     r_track     <= i_cfg_data;
                REG_RADIUS:    r_radius    <= i_cfg_data;
                REG_STEER_LIM: r_steer_lim <= i_cfg_data[14:0];
                REG_SPEED_LIM: r_speed_lim <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Effective limits: steering cap, and a zero wheelbase or radius acts as one.
    assign w_slim = (r_steer_lim > 15'(STEER_CAP)) ? 15'(STEER_CAP) : r_steer_lim;
    assign w_l    = (r_wheelbase == 16'd0) ? 16'd1 : r_wheelbase;
    assign w_r    = (r_radius == 16'd0) ? 16'd1 : r_radius;

    // The chain advances while the skid register is empty.
    assign w_en       = !r_skid_vld;
    assign o_in_stall = r_skid_vld;

    // Clamp the commands and seed the rotation.
    always_comb begin
        n_s0     = '0;
        w_sc     = {i_in_word.steer_cmd[15], i_in_word.steer_cmd};
        w_v      = {i_in_word.speed_cmd[15], i_in_word.speed_cmd};
        w_slim_s = signed'({2'b00, w_slim});
        w_vlim_s = signed'({2'b00, r_speed_lim});
        if (w_sc > w_slim_s) w_sc = w_slim_s;
        if (w_sc < -w_slim_s) w_sc = -w_slim_s;
        if (w_v > w_vlim_s) w_v = w_vlim_s;
        if (w_v < -w_vlim_s) w_v = -w_vlim_s;
        w_a = w_sc[16] ? -w_sc : w_sc;
        w_m = w_v[16] ? -w_v : w_v;
        n_s0.left     = (w_sc > 17'sd0);
        n_s0.straight = (w_a[14:0] <= 15'(DEAD_BAND));
        n_s0.vneg     = w_v[16];
        n_s0.m        = w_m[14:0];
        n_s0.rx       = 33'(KINV);
        n_s0.ry       = '0;
        n_s0.rz       = {2'b00, w_a[14:0], 16'd0};
    end

    assign w_rot_vld[0]  = r_s0_vld;
    assign w_rot_item[0] = r_s0;

    // Rotation chain.
    for (genvar k = 0; k < CORDIC_N; k++) begin : g_rot
        adk_rot_cell #(.STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_rot_vld[k]),
            .i_item (w_rot_item[k]),
            .o_vld  (w_rot_vld[k+1]),
            .o_item (w_rot_item[k+1])
        );
    end

    // Round sine and cosine to Q1.16.
    always_comb begin
        n_cs = w_rot_item[CORDIC_N];
        w_cr = {w_rot_item[CORDIC_N].rx[32], w_rot_item[CORDIC_N].rx} + 34'sd8192;
        w_sr = {w_rot_item[CORDIC_N].ry[32], w_rot_item[CORDIC_N].ry} + 34'sd8192;
        w_c  = w_cr >>> 14;
        w_s  = w_sr >>> 14;
        n_cs.c16 = (w_c < 34'sd1) ? 17'd1 : w_c[16:0];
        n_cs.s16 = w_s[33] ? 17'd0 : w_s[16:0];
    end

    // Wheelbase and track products.
    always_comb begin
        n_m1    = r_cs;
        n_m1.dc = {33'(w_l) * 33'(r_cs.c16), 1'b0};
        n_m1.ts = 33'(r_track) * 33'(r_cs.s16);
        n_m1.nv = {33'(w_l) * 33'(r_cs.s16), 1'b0};
    end

    // Outer and inner denominators, and the arctangent lanes.
    always_comb begin
        n_ad       = r_m1;
        w_dm       = signed'({2'b00, r_m1.dc}) - signed'({3'b000, r_m1.ts});
        n_ad.dp    = 35'(r_m1.dc) + 35'(r_m1.ts);
        n_ad.dmneg = w_dm[35];
        n_ad.fault = w_dm[35] || (w_dm == 36'sd0);
        n_ad.dmag  = w_dm[35] ? 35'(-w_dm) : w_dm[34:0];
        n_ad.ox    = {10'd0, n_ad.dp};
        n_ad.oy    = {11'd0, r_m1.nv};
        n_ad.ix    = n_ad.fault ? 45'sd1 : {10'd0, n_ad.dmag};
        n_ad.iy    = {11'd0, r_m1.nv};
        n_ad.oz    = '0;
        n_ad.iz    = '0;
    end

    // Normalize both lanes so that the larger operand has its top bit at 40.
    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int unsigned NS = 32 >> k;
        logic        w_src_vld;
        t_item       w_src;
        t_item       w_nxt;
        logic [44:0] w_oo;
        logic [44:0] w_ii;

        if (k == 0) begin : g_first
            assign w_src_vld = r_ad_vld;
            assign w_src     = r_ad;
        end else begin : g_next
            assign w_src_vld = r_nm_vld[k-1];
            assign w_src     = r_nm_item[k-1];
        end

        always_comb begin
            w_nxt = w_src;
            w_oo  = w_src.ox | w_src.oy;
            w_ii  = w_src.ix | w_src.iy;
            if (w_oo[44:41-NS] == '0) begin
                w_nxt.ox = w_src.ox <<< NS;
                w_nxt.oy = w_src.oy <<< NS;
            end
            if (w_ii[44:41-NS] == '0) begin
                w_nxt.ix = w_src.ix <<< NS;
                w_nxt.iy = w_src.iy <<< NS;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nm_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_nm_vld[k] <= w_src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_nm_item[k] <= w_nxt;
            end
        end
    end

    assign w_vec_vld[0]  = r_nm_vld[NORM_STEPS-1];
    assign w_vec_item[0] = r_nm_item[NORM_STEPS-1];

    // Vectoring chain.
    for (genvar k = 0; k < CORDIC_N; k++) begin : g_vec
        adk_vec_cell #(.STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_vec_vld[k]),
            .i_item (w_vec_item[k]),
            .o_vld  (w_vec_vld[k+1]),
            .o_item (w_vec_item[k+1])
        );
    end

    // Round the angles to Q2.14 and clamp to a quarter turn.
    always_comb begin
        n_an = w_vec_item[CORDIC_N];
        w_oa = (w_vec_item[CORDIC_N].oz + 33'sd32768) >>> 16;
        w_ia = (w_vec_item[CORDIC_N].iz + 33'sd32768) >>> 16;
        if (w_oa[32]) begin
            n_an.oang = 15'd0;
        end else if (w_oa > 33'(HALF_PI_Q14)) begin
            n_an.oang = 15'(HALF_PI_Q14);
        end else begin
            n_an.oang = w_oa[14:0];
        end
        if (w_vec_item[CORDIC_N].fault) begin
            n_an.iang = 15'(HALF_PI_Q14);
        end else if (w_ia[32]) begin
            n_an.iang = 15'd0;
        end else if (w_ia > 33'(HALF_PI_Q14)) begin
            n_an.iang = 15'(HALF_PI_Q14);
        end else begin
            n_an.iang = w_ia[14:0];
        end
    end

    // Speed and radius products.
    always_comb begin
        n_m2       = r_an;
        n_m2.p_mdp = 50'(r_an.m) * 50'(r_an.dp);
        n_m2.p_ldc = 49'(r_speed_lim) * 49'(r_an.dc);
        n_m2.p_mdm = 50'(r_an.m) * 50'(r_an.dmag);
        n_m2.p_ldm = 50'(r_speed_lim) * 50'(r_an.dmag);
        n_m2.p_dcr = 50'(r_an.dc) * 50'(w_r);
        n_m2.p_dpr = 51'(r_an.dp) * 51'(w_r);
    end

    // Pick dividends and divisors; rounding folds into 2n + d over 2d.
    always_comb begin
        n_se        = r_m2;
        n_se.scaled = !r_m2.straight && (r_m2.p_mdp > 50'(r_m2.p_ldc));
        if (r_m2.straight) begin
            w_no = {35'd0, r_m2.m, 12'd0};
            w_do = 51'(w_r);
            w_ni = {35'd0, r_m2.m, 12'd0};
            w_di = 51'(w_r);
        end else if (n_se.scaled) begin
            w_no = {35'd0, r_speed_lim, 12'd0};
            w_do = 51'(w_r);
            w_ni = {r_m2.p_ldm, 12'd0};
            w_di = r_m2.p_dpr;
        end else begin
            w_no = {r_m2.p_mdp, 12'd0};
            w_do = 51'(r_m2.p_dcr);
            w_ni = {r_m2.p_mdm, 12'd0};
            w_di = 51'(r_m2.p_dcr);
        end
        n_se.rem_o = 64'({w_no, 1'b0}) + 64'(w_do);
        n_se.rem_i = 64'({w_ni, 1'b0}) + 64'(w_di);
        n_se.dd_o  = {w_do, 1'b0};
        n_se.dd_i  = {w_di, 1'b0};
    end

    // Quotients too large for the divide chain saturate.
    always_comb begin
        n_ov       = r_se;
        n_ov.ovf_o = {5'd0, r_se.rem_o} >= ({17'd0, r_se.dd_o} << QW);
        n_ov.ovf_i = {5'd0, r_se.rem_i} >= ({17'd0, r_se.dd_i} << QW);
        n_ov.q_o   = '0;
        n_ov.q_i   = '0;
    end

    // Setup stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_cs_vld <= 1'b0;
            r_m1_vld <= 1'b0;
            r_ad_vld <= 1'b0;
            r_an_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_se_vld <= 1'b0;
            r_ov_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in_valid;
            r_cs_vld <= w_rot_vld[CORDIC_N];
            r_m1_vld <= r_cs_vld;
            r_ad_vld <= r_m1_vld;
            r_an_vld <= w_vec_vld[CORDIC_N];
            r_m2_vld <= r_an_vld;
            r_se_vld <= r_m2_vld;
            r_ov_vld <= r_se_vld;
        end
    end

    // Setup stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= n_s0;
            r_cs <= n_cs;
            r_m1 <= n_m1;
            r_ad <= n_ad;
            r_an <= n_an;
            r_m2 <= n_m2;
            r_se <= n_se;
            r_ov <= n_ov;
        end
    end

    assign w_div_vld[0]  = r_ov_vld;
    assign w_div_item[0] = r_ov;

    // Divide chain, most significant quotient bit first.
    for (genvar k = 0; k < QW; k++) begin : g_div
        adk_div_cell #(.STEP(QW - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_div_vld[k]),
            .i_item (w_div_item[k]),
            .o_vld  (w_div_vld[k+1]),
            .o_item (w_div_item[k+1])
        );
    end

    // Saturate a rate magnitude to a signed 16-bit value.
    function automatic logic signed [15:0] sat_rate(input logic [QW-1:0] q, input logic ovf,
                                                    input logic neg);
        logic [QW-1:0]      t;
        logic signed [15:0] r;
        t = '0;
        if (neg) begin
            if (ovf || (q > QW'(32768))) begin
                r = -16'sd32768;
            end else begin
                t = QW'(0) - q;
                r = t[15:0];
            end
        end else begin
            if (ovf || (q > QW'(32767))) begin
                r = 16'sd32767;
            end else begin
                r = q[15:0];
            end
        end
        return r;
    endfunction

    // Mirror for right turns and build the output word.
    always_comb begin
        t_item w_d;
        logic  w_ineg;
        w_d    = w_div_item[QW];
        w_ineg = w_d.vneg ^ w_d.dmneg;
        if (w_d.straight) begin
            w_fmt.left_angle     = '0;
            w_fmt.right_angle    = '0;
            w_fmt.left_rate      = sat_rate(w_d.q_o, w_d.ovf_o, w_d.vneg);
            w_fmt.right_rate     = sat_rate(w_d.q_o, w_d.ovf_o, w_d.vneg);
            w_fmt.speed_scaled   = 1'b0;
            w_fmt.geometry_fault = 1'b0;
        end else begin
            if (w_d.left) begin
                w_fmt.left_angle  = {1'b0, w_d.iang};
                w_fmt.right_angle = {1'b0, w_d.oang};
                w_fmt.left_rate   = sat_rate(w_d.q_i, w_d.ovf_i, w_ineg);
                w_fmt.right_rate  = sat_rate(w_d.q_o, w_d.ovf_o, w_d.vneg);
            end else begin
                w_fmt.left_angle  = 16'd0 - {1'b0, w_d.oang};
                w_fmt.right_angle = 16'd0 - {1'b0, w_d.iang};
                w_fmt.left_rate   = sat_rate(w_d.q_o, w_d.ovf_o, w_d.vneg);
                w_fmt.right_rate  = sat_rate(w_d.q_i, w_d.ovf_i, w_ineg);
            end
            w_fmt.speed_scaled   = w_d.scaled;
            w_fmt.geometry_fault = w_d.fault;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            if (w_div_vld[QW]) begin
                if (!r_out_vld || !i_out_stall) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end else if (!i_out_stall) begin
            r_skid_vld <= 1'b0;
        end
    end

    // Output and skid words.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_div_vld[QW]) begin
                if (!r_out_vld || !i_out_stall) begin
                    r_out_word <= w_fmt;
                end else begin
                    r_skid_word <= w_fmt;
                end
            end
        end else if (!i_out_stall) begin
            r_out_word <= r_skid_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // The skid register only holds a word behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while output register is empty");

    // The skid register fills only when the output was stalled.
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(i_out_stall))
        else $error("skid register filled without an output stall");

    // A geometry fault always shows the inner wheel at a quarter turn.
    a_fault_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.geometry_fault) |->
            (o_out_word.left_angle == 16'sd25736 || o_out_word.right_angle == -16'sd25736))
        else $error("geometry fault without a saturated inner angle");

endmodule

>>> rtl/adk_rot_cell.sv
// One rotation-mode CORDIC cell that turns the steering angle into sine and cosine.
module adk_rot_cell
    import adk_pkg::*;
#(
    parameter int unsigned STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic               r_vld;
    t_item              r_item;
    t_item              n_item;
    logic signed [32:0] w_x;
    logic signed [32:0] w_y;
    logic signed [32:0] w_z;
    logic signed [32:0] w_ang;

    // Rotate toward zero residual angle by one micro-rotation.
    always_comb begin
        n_item = i_item;
        w_x    = i_item.rx;
        w_y    = i_item.ry;
        w_z    = i_item.rz;
        w_ang  = signed'({3'b000, atan_q30(STEP)});
        if (!w_z[32]) begin
            n_item.rx = w_x - (w_y >>> STEP);
            n_item.ry = w_y + (w_x >>> STEP);
            n_item.rz = w_z - w_ang;
        end else begin
            n_item.rx = w_x + (w_y >>> STEP);
            n_item.ry = w_y - (w_x >>> STEP);
            n_item.rz = w_z + w_ang;
        end
    end

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

>>> rtl/adk_vec_cell.sv
// One vectoring-mode CORDIC cell that advances both front wheel arctangents.
module adk_vec_cell
    import adk_pkg::*;
#(
    parameter int unsigned STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic               r_vld;
    t_item              r_item;
    t_item              n_item;
    logic signed [44:0] w_ox;
    logic signed [44:0] w_oy;
    logic signed [32:0] w_oz;
    logic signed [44:0] w_ix;
    logic signed [44:0] w_iy;
    logic signed [32:0] w_iz;
    logic signed [32:0] w_ang;

    // Drive y toward zero in the outer and the inner lane.
    always_comb begin
        n_item = i_item;
        w_ox   = i_item.ox;
        w_oy   = i_item.oy;
        w_oz   = i_item.oz;
        w_ix   = i_item.ix;
        w_iy   = i_item.iy;
        w_iz   = i_item.iz;
        w_ang  = signed'({3'b000, atan_q30(STEP)});
        if (w_oy[44]) begin
            n_item.ox = w_ox - (w_oy >>> STEP);
            n_item.oy = w_oy + (w_ox >>> STEP);
            n_item.oz = w_oz - w_ang;
        end else begin
            n_item.ox = w_ox + (w_oy >>> STEP);
            n_item.oy = w_oy - (w_ox >>> STEP);
            n_item.oz = w_oz + w_ang;
        end
        if (w_iy[44]) begin
            n_item.ix = w_ix - (w_iy >>> STEP);
            n_item.iy = w_iy + (w_ix >>> STEP);
            n_item.iz = w_iz - w_ang;
        end else begin
            n_item.ix = w_ix + (w_iy >>> STEP);
            n_item.iy = w_iy - (w_ix >>> STEP);
            n_item.iz = w_iz + w_ang;
        end
    end

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

>>> rtl/adk_div_cell.sv
// One restoring-division cell that settles one quotient bit of both wheel rates.
module adk_div_cell
    import adk_pkg::*;
#(
    parameter int unsigned STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic        r_vld;
    t_item       r_item;
    t_item       n_item;
    logic [68:0] w_so;
    logic [68:0] w_si;

    // Subtract the shifted divisor where it fits.
    always_comb begin
        n_item = i_item;
        w_so   = {17'd0, i_item.dd_o} << STEP;
        w_si   = {17'd0, i_item.dd_i} << STEP;
        if ({5'd0, i_item.rem_o} >= w_so) begin
            n_item.rem_o     = i_item.rem_o - w_so[63:0];
            n_item.q_o[STEP] = 1'b1;
        end
        if ({5'd0, i_item.rem_i} >= w_si) begin
            n_item.rem_i     = i_item.rem_i - w_si[63:0];
            n_item.q_i[STEP] = 1'b1;
        end
    end

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

>>> tb/ackermann_drive_kinematics_tb.sv
// Self-checking testbench for the Ackermann steering and rear differential block.
`timescale 1ns / 100ps

module ackermann_drive_kinematics_tb
    import adk_pkg::*;
();

    localparam int  MAX_CYCLES = 600000;
    localparam int  TAIL_WAIT  = 120;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Scoreboard: predicts each result word and checks the block against it.
    class kin_scoreboard;
        t_out   pending_words[$];
        int     mismatches;
        int     checked;
        longint wheelbase;
        longint track;
        longint radius;
        longint steer_lim;
        longint speed_lim;
        longint atan_tab[24];

        function new();
            atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                         16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                         262143, 131071, 65535, 32767, 16383, 8191,
                         4095, 2047, 1023, 511, 255, 127};
            wheelbase = 9503;
            track     = 8716;
            radius    = 2195;
            steer_lim = 8192;
            speed_lim = 9830;
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_WHEELBASE: wheelbase = data;
                REG_TRACK:     track     = data;
                REG_RADIUS:    radius    = data;
                REG_STEER_LIM: steer_lim = data[14:0];
                REG_SPEED_LIM: speed_lim = data[14:0];
                default: ;
            endcase
        endfunction

        // Rounded division with the magnitude rounded half away from zero.
        function longint div_round(longint n, longint d);
            return (2 * n + d) / (2 * d);
        endfunction

        function logic [15:0] clip_rate(longint mag, bit neg);
            longint r;
            if (neg) begin
                r = -(mag > 32768 ? 32768 : mag);
            end else begin
                r = mag > 32767 ? 32767 : mag;
            end
            return r[15:0];
        endfunction

        // Vectoring arctangent of y/x in Q2.14 for x > 0 and y >= 0.
        function longint atan_q14(longint x, longint y);
            longint z, t, r;
            z = 0;
            while (x < 64'sd1099511627776 && y < 64'sd1099511627776) begin
                x = x * 2;
                y = y * 2;
            end
            for (int i = 0; i < 24; i++) begin
                t = x;
                if (y < 0) begin
                    x = x - (y >>> i);
                    y = y + (t >>> i);
                    z = z - atan_tab[i];
                end else begin
                    x = x + (y >>> i);
                    y = y - (t >>> i);
                    z = z + atan_tab[i];
                end
            end
            r = (z + 32768) >>> 16;
            if (r < 0) r = 0;
            if (r > HALF_PI_Q14) r = HALF_PI_Q14;
            return r;
        endfunction

        // Work out the result word of one accepted command word.
        function void note_command(t_in w);
            longint sc, v, slim, lb, rr, m, a, x, y, z, t;
            longint c16, s16, dc, dp, dm, nv, oang, iang, dmag, omag, imag;
            bit     vneg, fault, scaled, ineg;
            t_out   e;
            sc     = w.steer_cmd;
            v      = w.speed_cmd;
            slim   = steer_lim > STEER_CAP ? STEER_CAP : steer_lim;
            lb     = wheelbase != 0 ? wheelbase : 1;
            rr     = radius != 0 ? radius : 1;
            fault  = 0;
            scaled = 0;
            if (sc > slim) sc = slim;
            if (sc < -slim) sc = -slim;
            if (v > speed_lim) v = speed_lim;
            if (v < -speed_lim) v = -speed_lim;
            vneg = v < 0;
            m    = vneg ? -v : v;
            a    = sc < 0 ? -sc : sc;
            e    = '0;
            if (a <= DEAD_BAND) begin
                e.left_rate  = clip_rate(div_round(m * 4096, rr), vneg);
                e.right_rate = e.left_rate;
                pending_words.push_back(e);
                return;
            end
            // Rotation for sin and cos of the steering magnitude.
            x = KINV;
            y = 0;
            z = a * 65536;
            for (int i = 0; i < 24; i++) begin
                t = x;
                if (z >= 0) begin
                    x = x - (y >>> i);
                    y = y + (t >>> i);
                    z = z - atan_tab[i];
                end else begin
                    x = x + (y >>> i);
                    y = y - (t >>> i);
                    z = z + atan_tab[i];
                end
            end
            c16 = (x + 8192) >>> 14;
            s16 = (y + 8192) >>> 14;
            if (c16 < 1) c16 = 1;
            if (s16 < 0) s16 = 0;
            dc   = 2 * lb * c16;
            dp   = dc + track * s16;
            dm   = dc - track * s16;
            nv   = 2 * lb * s16;
            oang = atan_q14(dp, nv);
            if (dm <= 0) begin
                iang  = HALF_PI_Q14;
                fault = 1;
            end else begin
                iang = atan_q14(dm, nv);
            end
            dmag = dm < 0 ? -dm : dm;
            ineg = vneg != (dm < 0);
            if (m * dp > speed_lim * dc) begin
                scaled = 1;
                omag   = div_round(speed_lim * 4096, rr);
                imag   = div_round(speed_lim * dmag * 4096, dp * rr);
            end else begin
                omag = div_round(m * dp * 4096, dc * rr);
                imag = div_round(m * dmag * 4096, dc * rr);
            end
            // Left turns put the left wheel on the inside; right turns mirror it.
            if (sc > 0) begin
                e.left_angle  = iang[15:0];
                e.right_angle = oang[15:0];
                e.left_rate   = clip_rate(imag, ineg);
                e.right_rate  = clip_rate(omag, vneg);
            end else begin
                e.left_angle  = 16'(-oang);
                e.right_angle = 16'(-iang);
                e.left_rate   = clip_rate(omag, vneg);
                e.right_rate  = clip_rate(imag, ineg);
            end
            e.speed_scaled   = scaled;
            e.geometry_fault = fault;
            pending_words.push_back(e);
        endfunction

        task check_result(t_out got);
            t_out e;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected result word %h", got));
                return;
            end
            e = pending_words.pop_front();
            checked++;
            if (got.left_angle !== e.left_angle)
                report($sformatf("left_angle %0d, want %0d", got.left_angle, e.left_angle));
            if (got.right_angle !== e.right_angle)
                report($sformatf("right_angle %0d, want %0d", got.right_angle, e.right_angle));
            if (got.left_rate !== e.left_rate)
                report($sformatf("left_rate %0d, want %0d", got.left_rate, e.left_rate));
            if (got.right_rate !== e.right_rate)
                report($sformatf("right_rate %0d, want %0d", got.right_rate, e.right_rate));
            if (got.speed_scaled !== e.speed_scaled)
                report($sformatf("speed_scaled %b, want %b", got.speed_scaled, e.speed_scaled));
            if (got.geometry_fault !== e.geometry_fault)
                report($sformatf("geometry_fault %b, want %b",
                                 got.geometry_fault, e.geometry_fault));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_word;

    kin_scoreboard sb;
    bit  quiet;
    int  cycles;
    int  sent;
    int  faults_seen;
    int  scaled_seen;

    ackermann_drive_kinematics u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Write one register; the caller lowers the write enable afterwards.
    task cfg_write(logic [2:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task cfg_all(int wb, int tr, int rad, int sl, int vl);
        cfg_write(REG_WHEELBASE, wb[15:0]);
        cfg_write(REG_TRACK, tr[15:0]);
        cfg_write(REG_RADIUS, rad[15:0]);
        cfg_write(REG_STEER_LIM, sl[15:0]);
        cfg_write(REG_SPEED_LIM, vl[15:0]);
        // A write beyond the register list must change nothing.
        cfg_write(REG_UNUSED, 16'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present one command word and hold it until the block takes it.
    task send_word(logic [15:0] steer, logic [15:0] speed);
        t_in w;
        bit  taken;
        w.steer_cmd = steer;
        w.speed_cmd = speed;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        sb.note_command(w);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Lower valid and wait until every expected word has come back.
    task drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    // Random commands around the current limits, with some full-range noise.
    task random_words(int count);
        int st, sp, sl, vl;
        sl = sb.steer_lim > STEER_CAP ? STEER_CAP : int'(sb.steer_lim);
        vl = int'(sb.speed_lim);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0, 1:    st = $urandom;
                2:       st = $signed($urandom_range(0, 40)) - 20;
                default: st = $signed($urandom_range(0, 2 * sl + 40)) - sl - 20;
            endcase
            if ($urandom_range(0, 2) == 0) begin
                sp = $urandom;
            end else begin
                sp = $signed($urandom_range(0, 2 * vl + 20)) - vl - 10;
            end
            send_word(st[15:0], sp[15:0]);
        end
    endtask

    // Result side: random stall bursts, words checked as they are taken.
    initial begin
        int   burst;
        bit   take;
        t_out w;
        burst = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            take = o_out_valid && !i_out_stall;
            w = o_out_word;
            @(posedge i_clk);
            if (take && i_rst_n) begin
                sb.check_result(w);
                faults_seen += w.geometry_fault;
                scaled_seen += w.speed_scaled;
            end
            if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 5);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Main sequence: reset, directed cases, random phases, then the final check.
    initial begin
        int wb, tr;
        sb = new();
        quiet = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_WHEELBASE;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: dead band edges, clamps and extremes of both commands.
        send_word(16'sd0, 16'sd0);
        send_word(16'sd32767, 16'sd32767);
        send_word(-16'sd32768, -16'sd32768);
        send_word(16'sd16, 16'sd5000);
        send_word(-16'sd16, -16'sd5000);
        send_word(16'sd17, 16'sd5000);
        send_word(-16'sd17, 16'sd5000);
        send_word(16'sd8192, 16'sd9830);
        send_word(-16'sd8193, -16'sd9831);
        send_word(16'sd4000, 16'sd1);
        send_word(-16'sd4000, -16'sd1);
        drain();

        // Wide track on a short car: the inner wheel geometry breaks down.
        cfg_all(1000, 65535, 1, 25000, 32767);
        send_word(16'sd25000, 16'sd32767);
        send_word(-16'sd25000, -16'sd32767);
        send_word(16'sd3000, 16'sd20000);
        send_word(-16'sd300, 16'sd100);
        drain();

        // Zero wheelbase and radius act as one; steer limit above the cap.
        cfg_all(0, 0, 0, 32767, 0);
        send_word(16'sd32767, 16'sd32767);
        send_word(-16'sd20000, -16'sd100);
        send_word(16'sd5, 16'sd0);
        drain();

        cfg_all(65535, 65535, 65535, 0, 32767);
        send_word(16'sd32767, 16'sd32767);
        send_word(-16'sd32768, -16'sd32768);
        drain();

        // Random phases with fresh geometry; the sender waits out each one.
        for (int ph = 0; ph < 7; ph++) begin
            wb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3000) : $urandom_range(1, 65535);
            tr = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
            cfg_all(wb, tr, $urandom_range(0, 65535), $urandom_range(0, 32767),
                    $urandom_range(0, 32767));
            random_words(170);
            drain();
        end

        // Last part: default geometry, no idling on either side.
        quiet = 1;
        cfg_all(9503, 8716, 2195, 8192, 9830);
        random_words(200);
        drain();

        $display("Sent %0d command words, checked %0d results under 11 register settings.",
                 sent, sb.checked);
        $display("Results with wheel speed scaling: %0d, with inner geometry fault: %0d.",
                 scaled_seen, faults_seen);
        if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
